[rtl/eti_pkg.sv]
// Shared types, constants and sequencer states of the escape-time iterator.
package eti_pkg;

    localparam int DATA_W         = 32;
    localparam int PROD_W         = 2 * DATA_W;
    localparam int ITER_W         = 16;
    localparam int FRAC_BITS_DEF  = 28;
    localparam int COUNT_BITS_DEF = 16;

    localparam logic [ITER_W-1:0] MAX_ITER_RST = 16'd100;

    typedef struct packed {
        logic signed [DATA_W-1:0] z_re;
        logic signed [DATA_W-1:0] z_im;
        logic signed [DATA_W-1:0] c_re;
        logic signed [DATA_W-1:0] c_im;
    } eti_point_t;

    typedef struct packed {
        logic [ITER_W-1:0] iter_count;
        logic              escaped;
    } eti_res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_RE,
        ST_SQ_IM,
        ST_CROSS,
        ST_TEST,
        ST_UPDATE,
        ST_DONE
    } eti_state_t;

endpackage

[rtl/eti_if.sv]
// Channel interfaces: input points, results and the iteration limit write port.
interface eti_in_if import eti_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] z_re;
    logic signed [DATA_W-1:0] z_im;
    logic signed [DATA_W-1:0] c_re;
    logic signed [DATA_W-1:0] c_im;

    modport source (output valid, output z_re, output z_im, output c_re, output c_im,
                    input ready);
    modport sink   (input valid, input z_re, input z_im, input c_re, input c_im,
                    output ready);
endinterface

interface eti_out_if import eti_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ITER_W-1:0] iter_count;
    logic              escaped;

    modport source (output valid, output iter_count, output escaped, input ready);
    modport sink   (input valid, input iter_count, input escaped, output ready);
endinterface

interface eti_cfg_if import eti_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ITER_W-1:0] max_iterations;

    modport source (output valid, output max_iterations, input ready);
    modport sink   (input valid, input max_iterations, output ready);
endinterface

[rtl/eti_mult.sv]
// Shared signed 32x32 multiplier with registered 64-bit product.
module eti_mult import eti_pkg::*;
(
    input  logic                     clk,
    input  logic                     mul_en,
    input  logic signed [DATA_W-1:0] mul_a,
    input  logic signed [DATA_W-1:0] mul_b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

[rtl/eti_core.sv]
// Iteration sequencer: holds z and c, steers the shared multiplier, tests and updates.
module eti_core import eti_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  eti_point_t               point,
    output logic                     ready,
    input  logic [ITER_W-1:0]        max_iterations,
    output logic                     mul_en,
    output logic signed [DATA_W-1:0] mul_a,
    output logic signed [DATA_W-1:0] mul_b,
    input  logic signed [PROD_W-1:0] prod,
    output logic                     res_valid,
    output eti_res_t                 res,
    input  logic                     res_ready
);

    localparam int WIDE      = (COUNT_BITS > ITER_W) ? COUNT_BITS : ITER_W;
    localparam int ESC_SHIFT = 2 * FRAC_BITS + 2;
    localparam logic [WIDE-1:0] CAP = WIDE'((64'd1 << COUNT_BITS) - 64'd1);

    function automatic logic signed [DATA_W-1:0] sat_data(
        input logic signed [PROD_W-1:0] x
    );
        logic [PROD_W-DATA_W:0] upper;
        logic signed [DATA_W-1:0] r;
        upper = x[PROD_W-1:DATA_W-1];
        if (upper == '0 || upper == '1)
        begin
            r = x[DATA_W-1:0];
        end
        else if (x[PROD_W-1])
        begin
            r = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

    eti_state_t state_reg, state_next;

    logic signed [DATA_W-1:0] zr_reg, zr_next;
    logic signed [DATA_W-1:0] zi_reg, zi_next;
    logic signed [DATA_W-1:0] cr_reg, cr_next;
    logic signed [DATA_W-1:0] ci_reg, ci_next;
    logic signed [PROD_W-1:0] rr_reg, rr_next;
    logic signed [PROD_W-1:0] ii_reg, ii_next;
    logic signed [PROD_W-1:0] diff_reg, diff_next;
    logic [COUNT_BITS-1:0]    count_reg, count_next;
    logic                     esc_reg, esc_next;

    logic [PROD_W-1:0]        mag;
    logic                     escape;
    logic [WIDE-1:0]          limit;
    logic [WIDE-1:0]          count_wide;
    logic signed [PROD_W-1:0] re_wide;
    logic signed [PROD_W-1:0] im_wide;

    // exact |z|^2 against 4.0; the bound drops out when it passes 64 bits
    assign mag    = $unsigned(rr_reg) + $unsigned(ii_reg);
    assign escape = (mag >> ESC_SHIFT) != '0;

    assign count_wide = WIDE'(count_reg);
    assign limit      = (WIDE'(max_iterations) < CAP) ? WIDE'(max_iterations) : CAP;

    // prod still holds zr*zi while in update
    assign re_wide = (diff_reg >>> FRAC_BITS) + PROD_W'(cr_reg);
    assign im_wide = (prod >>> (FRAC_BITS - 1)) + PROD_W'(ci_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zr_reg   <= zr_next;
        zi_reg   <= zi_next;
        cr_reg   <= cr_next;
        ci_reg   <= ci_next;
        rr_reg   <= rr_next;
        ii_reg   <= ii_next;
        diff_reg <= diff_next;
        esc_reg  <= esc_next;
    end

    always_comb
    begin
        state_next = state_reg;
        zr_next    = zr_reg;
        zi_next    = zi_reg;
        cr_next    = cr_reg;
        ci_next    = ci_reg;
        rr_next    = rr_reg;
        ii_next    = ii_reg;
        diff_next  = diff_reg;
        count_next = count_reg;
        esc_next   = esc_reg;
        mul_en     = 1'b0;
        mul_a      = zr_reg;
        mul_b      = zr_reg;
        ready      = 1'b0;
        res_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                ready = 1'b1;
                if (start)
                begin
                    zr_next    = point.z_re;
                    zi_next    = point.z_im;
                    cr_next    = point.c_re;
                    ci_next    = point.c_im;
                    count_next = '0;
                    state_next = ST_SQ_RE;
                end
            end
            ST_SQ_RE:
            begin
                mul_en     = 1'b1;
                state_next = ST_SQ_IM;
            end
            ST_SQ_IM:
            begin
                mul_en     = 1'b1;
                mul_a      = zi_reg;
                mul_b      = zi_reg;
                rr_next    = prod;
                state_next = ST_CROSS;
            end
            ST_CROSS:
            begin
                mul_en     = 1'b1;
                mul_a      = zr_reg;
                mul_b      = zi_reg;
                ii_next    = prod;
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                esc_next  = escape;
                diff_next = rr_reg - ii_reg;
                if (escape || count_wide >= limit)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                zr_next    = sat_data(re_wide);
                zi_next    = sat_data(im_wide);
                count_next = COUNT_BITS'(count_reg + 1'b1);
                state_next = ST_SQ_RE;
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res.iter_count = ITER_W'(count_wide);
    assign res.escaped    = esc_reg;

endmodule

[rtl/escape_time_iterator.sv]
// Top level of the escape-time iterator: limit register, core, multiplier, result register.
//
//   channel  modport  payload                          beat
//   point    sink     z_re, z_im, c_re, c_im (Q4.28)   one point to iterate
//   result   source   iter_count, escaped              one result per point
//   cfg      sink     max_iterations                   new iteration limit
//
// Each iteration of a point steps through SQ_RE, SQ_IM, CROSS, TEST and UPDATE;
// the one shared 32x32 multiplier forms three products per iteration, and the
// escape test and the z update have a state each.
// point.ready is high only while the core is idle; one result can wait in the
// output register while the next point is taken. cfg is always ready.
// Reset (rst_n, async) sets the limit to 100 and empties the block.
module escape_time_iterator import eti_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    eti_in_if.sink    point,
    eti_out_if.source result,
    eti_cfg_if.sink   cfg
);

    logic [ITER_W-1:0]        max_iter_reg, max_iter_next;
    logic                     out_valid_reg, out_valid_next;
    eti_res_t                 out_res_reg, out_res_next;

    eti_point_t               pt;
    logic                     core_ready;
    logic                     core_res_valid;
    eti_res_t                 core_res;
    logic                     res_ready;
    logic                     mul_en;
    logic signed [DATA_W-1:0] mul_a;
    logic signed [DATA_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod;

    assign pt.z_re = point.z_re;
    assign pt.z_im = point.z_im;
    assign pt.c_re = point.c_re;
    assign pt.c_im = point.c_im;

    assign point.ready = core_ready;
    assign cfg.ready   = 1'b1;

    eti_core #(
        .FRAC_BITS  (FRAC_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (point.valid),
        .point          (pt),
        .ready          (core_ready),
        .max_iterations (max_iter_reg),
        .mul_en         (mul_en),
        .mul_a          (mul_a),
        .mul_b          (mul_b),
        .prod           (prod),
        .res_valid      (core_res_valid),
        .res            (core_res),
        .res_ready      (res_ready)
    );

    eti_mult u_mult (
        .clk    (clk),
        .mul_en (mul_en),
        .mul_a  (mul_a),
        .mul_b  (mul_b),
        .prod   (prod)
    );

    // take a finished result when the output slot is empty or draining
    assign res_ready = !out_valid_reg || result.ready;

    always_comb
    begin
        max_iter_next  = max_iter_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (cfg.valid)
        begin
            max_iter_next = cfg.max_iterations;
        end
        if (core_res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_res_next   = core_res;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg  <= MAX_ITER_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            max_iter_reg  <= max_iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign result.valid      = out_valid_reg;
    assign result.iter_count = out_res_reg.iter_count;
    assign result.escaped    = out_res_reg.escaped;

    a_accept_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        point.valid && point.ready |-> !core_res_valid)
        else $error("point accepted while core holds a result");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        point.valid && point.ready |=> !point.ready)
        else $error("core ready again right after accepting a point");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        core_res_valid && res_ready |=> result.valid
            && result.iter_count == $past(core_res.iter_count)
            && result.escaped == $past(core_res.escaped))
        else $error("finished result not presented on the output");

endmodule

[dv/escape_time_iterator_tb.sv]
// Self-checking testbench of the escape-time iterator: point, result and limit channels.
module escape_time_iterator_tb;
    import eti_pkg::*;

    localparam int unsigned MAX_CYCLES = 5_000_000;
    localparam int unsigned DRAIN_WAIT = 30;

    localparam logic signed [DATA_W-1:0] Q_ZERO    = 32'sh0000_0000;
    localparam logic signed [DATA_W-1:0] Q_LSB     = 32'sh0000_0001;
    localparam logic signed [DATA_W-1:0] Q_QUARTER = 32'sh0400_0000;
    localparam logic signed [DATA_W-1:0] Q_ONE     = 32'sh1000_0000;
    localparam logic signed [DATA_W-1:0] Q_1P4     = 32'sh1666_6666;
    localparam logic signed [DATA_W-1:0] Q_1P9     = 32'sh1E66_6666;
    localparam logic signed [DATA_W-1:0] Q_TWO     = 32'sh2000_0000;
    localparam logic signed [DATA_W-1:0] Q_2P5     = 32'sh2800_0000;
    localparam logic signed [DATA_W-1:0] Q_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN     = 32'sh8000_0000;

    // Expected results of the escape-time recurrence, oldest first.
    class escape_tracker;
        logic [ITER_W-1:0] limit;
        eti_res_t          expected_q[$];
        int unsigned       mismatches;
        int unsigned       points;
        int unsigned       escapes;
        int unsigned       deepest;

        function new();
            limit = MAX_ITER_RST;
        endfunction

        function bit beyond_radius(longint zr, longint zi);
            logic [63:0] mag;
            mag = 64'(zr * zr) + 64'(zi * zi);
            return mag >= (64'd1 << (2 * FRAC_BITS_DEF + 2));
        endfunction

        function longint clamp32(longint x);
            if (x > longint'(Q_MAX))
                return longint'(Q_MAX);
            if (x < longint'(Q_MIN))
                return longint'(Q_MIN);
            return x;
        endfunction

        function eti_res_t iterate(eti_point_t p);
            longint      zr;
            longint      zi;
            longint      cr;
            longint      ci;
            longint      re_next;
            longint      im_next;
            int unsigned cap;
            int unsigned lim;
            int unsigned n;
            bit          gone;
            eti_res_t    r;
            zr = longint'($signed(p.z_re));
            zi = longint'($signed(p.z_im));
            cr = longint'($signed(p.c_re));
            ci = longint'($signed(p.c_im));
            cap = (1 << COUNT_BITS_DEF) - 1;
            lim = (limit < cap) ? limit : cap;
            n = 0;
            gone = beyond_radius(zr, zi);
            while (!gone && n < lim)
            begin
                re_next = clamp32(((zr * zr - zi * zi) >>> FRAC_BITS_DEF) + cr);
                im_next = clamp32(((zr * zi) >>> (FRAC_BITS_DEF - 1)) + ci);
                zr = re_next;
                zi = im_next;
                n++;
                gone = beyond_radius(zr, zi);
            end
            r.iter_count = ITER_W'(n);
            r.escaped = gone;
            return r;
        endfunction

        function void note_point(eti_point_t p);
            eti_res_t r;
            r = iterate(p);
            expected_q.push_back(r);
            points++;
            if (r.escaped)
                escapes++;
            if (r.iter_count > deepest)
                deepest = r.iter_count;
        endfunction

        function void check_result(eti_res_t got);
            eti_res_t want;
            if (expected_q.size() == 0)
            begin
                $error("result beat with no point outstanding: iter_count=%0d escaped=%0d",
                       got.iter_count, got.escaped);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (got.iter_count !== want.iter_count)
            begin
                $error("iter_count: expected %0d, got %0d", want.iter_count, got.iter_count);
                mismatches++;
            end
            if (got.escaped !== want.escaped)
            begin
                $error("escaped: expected %0d, got %0d", want.escaped, got.escaped);
                mismatches++;
            end
        endfunction

        function int unsigned outstanding();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    eti_in_if  point_if ();
    eti_out_if result_if ();
    eti_cfg_if cfg_if ();

    escape_time_iterator u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .point  (point_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    escape_tracker book = new();
    bit            tx_calm;
    bit            rx_calm;
    int unsigned   limit_writes;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < MAX_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Beats seen at the rising edge feed the tracker.
    always @(posedge clk)
    begin
        if (rst_n && point_if.valid && point_if.ready)
            book.note_point('{point_if.z_re, point_if.z_im, point_if.c_re, point_if.c_im});
        if (rst_n && result_if.valid && result_if.ready)
            book.check_result('{result_if.iter_count, result_if.escaped});
        if (rst_n && cfg_if.valid && cfg_if.ready)
        begin
            book.limit = cfg_if.max_iterations;
            limit_writes++;
        end
    end

    // Result side: unless rx_calm is set, stall a random number of cycles before each beat.
    initial
    begin
        int unsigned stall;
        result_if.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = rx_calm ? 0 : $urandom_range(0, 11);
            if (stall != 0)
            begin
                result_if.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_if.ready = 1'b1;
            do @(posedge clk); while (!result_if.valid);
            @(negedge clk);
        end
    end

    function automatic logic signed [DATA_W-1:0] rand_box(int unsigned half);
        return DATA_W'($urandom_range(0, 2 * half - 1)) - DATA_W'(half);
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_big();
        logic signed [DATA_W-1:0] v;
        v = DATA_W'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF));
        return $urandom_range(0, 1) ? v : -v;
    endfunction

    task automatic send_point(input logic signed [DATA_W-1:0] zr, zi, cr, ci);
        int unsigned gap;
        gap = tx_calm ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            point_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        point_if.valid = 1'b1;
        point_if.z_re = zr;
        point_if.z_im = zi;
        point_if.c_re = cr;
        point_if.c_im = ci;
        do @(posedge clk); while (!point_if.ready);
        @(negedge clk);
    endtask

    // Hold the sender until every outstanding result has come back.
    task automatic drain();
        point_if.valid = 1'b0;
        while (book.outstanding() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_limit(input logic [ITER_W-1:0] v);
        drain();
        cfg_if.valid = 1'b1;
        cfg_if.max_iterations = v;
        do @(posedge clk); while (!cfg_if.ready);
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic send_random();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            // Mandelbrot-style: z at or near the origin, c over the whole set
            if ($urandom_range(0, 3) == 0)
                send_point(rand_box(1 << 24), rand_box(1 << 24),
                           rand_box(Q_TWO), rand_box(Q_TWO));
            else
                send_point(Q_ZERO, Q_ZERO, rand_box(Q_TWO), rand_box(Q_TWO));
        end
        else if (pick < 75)
            send_point(rand_box(Q_TWO), rand_box(Q_TWO), rand_box(Q_ONE), rand_box(Q_ONE));
        else if (pick < 85)
        begin
            // drive one or both parts of the update into saturation
            if ($urandom_range(0, 1))
                send_point(rand_box(Q_1P9), rand_box(Q_1P9), rand_big(), rand_big());
            else if ($urandom_range(0, 1))
                send_point(rand_box(Q_1P9), rand_box(Q_1P9), rand_big(), rand_box(Q_ONE));
            else
                send_point(rand_box(Q_1P9), rand_box(Q_1P9), rand_box(Q_ONE), rand_big());
        end
        else
            send_point($urandom, $urandom, $urandom, $urandom);
    endtask

    initial
    begin
        int unsigned phase_limit[7];
        int unsigned phase_items[7];
        rst_n = 1'b0;
        point_if.valid = 1'b0;
        point_if.z_re = '0;
        point_if.z_im = '0;
        point_if.c_re = '0;
        point_if.c_im = '0;
        cfg_if.valid = 1'b0;
        cfg_if.max_iterations = '0;
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        limit_writes = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset limit: inside points, exact radius, sign extremes, saturation, floor on negatives
        send_point(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);
        send_point(Q_TWO, Q_ZERO, Q_ZERO, Q_ZERO);
        send_point(Q_TWO - Q_LSB, Q_ZERO, Q_ZERO, Q_ZERO);
        send_point(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        send_point(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        send_point(Q_ZERO, Q_ZERO, -Q_TWO, Q_ZERO);
        send_point(Q_ZERO, Q_ZERO, Q_QUARTER, Q_ZERO);
        send_point(Q_ZERO, Q_ZERO, -Q_ONE, Q_ZERO);
        send_point(Q_1P9, Q_ZERO, Q_MAX, Q_ZERO);
        send_point(Q_1P9, Q_ZERO, Q_MIN, Q_MIN);
        send_point(Q_1P4, Q_1P4, Q_ZERO, Q_MAX);
        send_point(Q_ZERO, Q_1P9, Q_ZERO, Q_ZERO);
        send_point(Q_LSB, -Q_LSB, Q_ZERO, Q_ZERO);
        send_point(-Q_LSB, -Q_LSB, -Q_LSB, Q_LSB);

        // Limit of one: escape on the last step, and a point held at the limit
        write_limit(16'd1);
        send_point(Q_ZERO, Q_ZERO, Q_2P5, Q_ZERO);
        send_point(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);

        // Limit of zero: only the test on the starting z
        write_limit(16'd0);
        send_point(Q_TWO, Q_ZERO, Q_ZERO, Q_ZERO);
        send_point(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);

        // Full-width limit: one point runs the whole count, the rest leave fast
        write_limit(16'hFFFF);
        send_point(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);
        send_point(Q_ZERO, Q_ZERO, -Q_TWO, Q_ZERO);
        send_point(Q_ZERO, Q_ZERO, rand_big(), rand_box(Q_ONE));

        phase_limit = '{1, 16, 100, 255, 1000, 0, $urandom_range(2, 200)};
        phase_items = '{120, 150, 300, 200, 50, 60, 270};
        for (int ph = 0; ph < 7; ph++)
        begin
            write_limit(ITER_W'(phase_limit[ph]));
            tx_calm = (ph == 2) || ($urandom_range(0, 3) == 0);
            rx_calm = (ph == 2) || ($urandom_range(0, 3) == 0);
            for (int k = 0; k < phase_items[ph]; k++)
            begin
                if (k == phase_items[ph] / 2 || $urandom_range(0, 49) == 0)
                    drain();
                send_random();
            end
        end

        drain();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (book.outstanding() != 0)
        begin
            $error("%0d results never arrived", book.outstanding());
            book.mismatches++;
        end
        $display("Iterated %0d points under %0d limit settings: %0d escaped, %0d held at the limit.",
                 book.points, limit_writes + 1, book.escapes, book.points - book.escapes);
        $display("Deepest iteration count reached: %0d.", book.deepest);
        if (book.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sim.f]
rtl/eti_pkg.sv
rtl/eti_if.sv
rtl/eti_mult.sv
rtl/eti_core.sv
rtl/escape_time_iterator.sv
dv/escape_time_iterator_tb.sv
